// File: hw/rtl/fmbv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fmbv_pkg;
   localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
   localparam logic [23:0] ENV_ONE = 24'hFF_FFFF;

   typedef enum logic [2:0] {
      CSR_CARRIER_STEP = 3'd0,
      CSR_MOD_STEP     = 3'd1,
      CSR_MOD_DEPTH    = 3'd2,
      CSR_MOD_DECAY    = 3'd3,
      CSR_AMP_DECAY_A  = 3'd4,
      CSR_AMP_DECAY_B  = 3'd5,
      CSR_GAP_SAMPLES  = 3'd6,
      CSR_BURST_COUNT  = 3'd7
   } csr_index_type;

   // shared multiplier operation: signed a times unsigned b; the user selects bits of the product
   typedef struct packed {
      logic signed [32:0] a;
      logic [31:0]        b;
   } mul_req_type;
endpackage
`default_nettype wire

// File: hw/rtl/fmbv_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module fmbv_mul (
   input  wire logic                clock,
   input  fmbv_pkg::mul_req_type    op,
   output logic signed [65:0]       prod_ff
);
   import fmbv_pkg::*;
   logic signed [65:0] prod_in;
   // registered 33 x 33 signed multiply (b zero extended)
   assign prod_in = op.a * $signed({1'b0, op.b});
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// File: hw/rtl/fmbv_sine.sv
`timescale 1ns / 1ps
`default_nettype none
module fmbv_sine #(
   parameter int ADDR_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic [31:0]        phase,
   output logic signed [15:0]      sine_ff
);
   localparam int HALF = 1 << (ADDR_BITS - 1);
   logic [ADDR_BITS-1:0]     idx;
   logic                     neg;
   logic [ADDR_BITS-1:0]     mag;
   logic [2*ADDR_BITS-1:0]   prod;
   logic [2*ADDR_BITS+18:0]  shifted;
   logic [18:0]              val;
   logic [15:0]              clip;
   logic signed [15:0]       sine_in;

   assign idx  = phase[31 -: ADDR_BITS];
   assign neg  = idx[ADDR_BITS-1];
   assign mag  = neg ? ADDR_BITS'(2 * HALF - int'(idx)) : idx;
   assign prod = mag * (ADDR_BITS'(HALF) - mag);
   assign shifted = {prod, 19'd0};
   assign val  = shifted[2*ADDR_BITS+18 : 2*ADDR_BITS];
   assign clip = (val > 19'd32767) ? 16'd32767 : val[15:0];
   assign sine_in = neg ? -$signed(clip) : $signed(clip);
   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end
endmodule
`default_nettype wire

// File: hw/rtl/fm_burst_voice.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | ports
// request  | in        | req_valid, req_ready, req_retrigger
// result   | out       | rsp_valid, rsp_ready, rsp_sample_out, rsp_voice_active
// config   | in        | csr_valid, csr_ready, csr_index, csr_data
//
// a sounding request runs 12 sequencer steps: one shared 33x33 multiplier is used
// seven times (feedback, depth, offset, amplitude, high-pass, two envelopes) with a
// registered sine stage in between; its result is raised from the S_AENV step
// an idle request (no retrigger, voice silent) goes straight to S_DONE, which gives a zero result
// a new request is taken only in S_IDLE, never while the previous one is still in the sequencer
// reset is synchronous: state and configuration registers take their defaults, the voice is silent
// a result waits in the output register; no request is taken until it is delivered
module fm_burst_voice #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int FEEDBACK_DEPTH = 10430,
   parameter int HPF_ALPHA      = 59415
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_retrigger,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_sample_out,
   output logic             rsp_voice_active,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import fmbv_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_FB    = 14'b00000000000010,
      S_MPH   = 14'b00000000000100,
      S_MSIN  = 14'b00000000001000,
      S_DEP   = 14'b00000000010000,
      S_OFF   = 14'b00000000100000,
      S_CSIN  = 14'b00000001000000,
      S_AMP   = 14'b00000010000000,
      S_SCL   = 14'b00000100000000,
      S_HP    = 14'b00001000000000,
      S_HPW   = 14'b00010000000000,
      S_MENV  = 14'b00100000000000,
      S_AENV  = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [31:0] carrier_step_ff, mod_step_ff;
   logic [19:0] mod_depth_ff;
   logic [23:0] mod_decay_ff, amp_decay_a_ff, amp_decay_b_ff;
   logic [15:0] gap_samples_ff;
   logic [6:0]  burst_count_ff;

   // voice state
   logic [31:0] mod_ph_ff, car_ph_ff;
   logic signed [15:0] last_mod_ff;
   logic [23:0] amp_env_ff, mod_env_ff;
   logic signed [15:0] hp_in_ff;
   logic signed [17:0] hp_out_ff;
   logic [7:0]  stage_ff;
   logic [15:0] gap_ff;
   logic        sounding_ff;

   // per-request scratch
   logic [19:0] depth_ff;         // envelope-scaled modulation depth
   logic        tone_neg_ff;      // sign of the carrier sine
   logic signed [15:0] x_ff;      // amplitude-scaled tone
   logic        hp_neg_ff;        // sign of the high-pass sum
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] sample_ff;

   mul_req_type mul_op;
   logic signed [65:0] prod;
   logic signed [15:0] sine;
   logic [31:0] sine_phase;
   logic        req_take;

   // magnitude helpers for truncation toward zero
   logic [15:0] tone_abs;
   logic [15:0] x_mag;
   logic signed [15:0] x_val;
   logic signed [18:0] hp_s;
   logic [18:0] hp_abs;
   logic [18:0] hp_mag;
   logic signed [17:0] hp_sat;
   logic signed [15:0] sample_sat;
   logic [7:0]  stage_next;
   logic [15:0] gap_next;
   logic [23:0] decay;

   fmbv_mul u_mul (.clock(clock), .op(mul_op), .prod_ff(prod));
   fmbv_sine #(.ADDR_BITS(SINE_ADDR_BITS)) u_sine (
      .clock(clock), .phase(sine_phase), .sine_ff(sine));

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_voice_active = sounding_ff;
   // modulator phase only while its sine is formed, carrier phase otherwise
   assign sine_phase = (state_ff == S_MSIN) ? mod_ph_ff : car_ph_ff;

   // carrier sine magnitude for the amplitude multiply
   assign tone_abs = sine[15] ? 16'(-sine) : 16'(sine);
   // tone times amp_env over 2^24, sign restored
   assign x_mag = prod[39:24];
   assign x_val = tone_neg_ff ? -$signed(x_mag) : $signed(x_mag);
   // high-pass sum and its magnitude
   assign hp_s   = 19'(hp_out_ff) + 19'(x_ff) - 19'(hp_in_ff);
   assign hp_abs = hp_s[18] ? 19'(-hp_s) : 19'(hp_s);
   assign hp_mag = prod[34:16];

   // high-pass output saturated to 18 bits
   always_comb begin
      if (hp_neg_ff)
         hp_sat = (hp_mag >= 19'd131072) ? 18'h2_0000 : -$signed(hp_mag[17:0]);
      else
         hp_sat = (hp_mag > 19'd131071) ? 18'h1_FFFF : $signed(hp_mag[17:0]);
   end

   assign sample_sat = (hp_sat > 18'sd32767) ? 16'h7FFF
                     : (hp_sat < -18'sd32768) ? 16'h8000 : hp_sat[15:0];
   assign decay = (stage_ff < {1'b0, burst_count_ff}) ? amp_decay_a_ff : amp_decay_b_ff;
   assign gap_next = gap_ff + 16'd1;
   assign stage_next = stage_ff + 8'd1;

   // shared multiplier operands, product is seen one step later
   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      unique case (state_ff)
         S_FB:   begin mul_op.a = 33'(last_mod_ff); mul_op.b = 32'(2 * FEEDBACK_DEPTH); end
         S_MPH:  begin mul_op.a = 33'(mod_depth_ff); mul_op.b = 32'(mod_env_ff); end
         S_DEP:  begin mul_op.a = 33'(sine); mul_op.b = {11'd0, depth_ff, 1'b0}; end
         S_AMP:  begin mul_op.a = 33'(tone_abs); mul_op.b = 32'(amp_env_ff); end
         S_HP:   begin mul_op.a = 33'(hp_abs); mul_op.b = 32'(HPF_ALPHA); end
         S_HPW:  begin mul_op.a = 33'(mod_env_ff); mul_op.b = 32'(mod_decay_ff); end
         S_MENV: begin mul_op.a = 33'(amp_env_ff); mul_op.b = 32'(decay); end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_take)
                    state_in = (req_retrigger || sounding_ff) ? S_FB : S_DONE;
         S_FB:   state_in = S_MPH;
         S_MPH:  state_in = S_MSIN;
         S_MSIN: state_in = S_DEP;
         S_DEP:  state_in = S_OFF;
         S_OFF:  state_in = S_CSIN;
         S_CSIN: state_in = S_AMP;
         S_AMP:  state_in = S_SCL;
         S_SCL:  state_in = S_HP;
         S_HP:   state_in = S_HPW;
         S_HPW:  state_in = S_MENV;
         S_MENV: state_in = S_AENV;
         S_AENV: state_in = S_IDLE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // result raised at the last step, dropped once delivered
   always_comb begin
      if ((state_ff == S_AENV) || (state_ff == S_DONE))
         rsp_valid_in = 1'b1;
      else
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sounding_ff <= 1'b0;
         sample_ff <= '0;
         carrier_step_ff <= 32'd21009906;
         mod_step_ff <= 32'd95444016;
         mod_depth_ff <= 20'd35787;
         mod_decay_ff <= 24'd16775160;
         amp_decay_a_ff <= 24'd16762019;
         amp_decay_b_ff <= 24'd16776051;
         gap_samples_ff <= 16'd1344;
         burst_count_ff <= 7'd2;
         mod_ph_ff <= PHASE_QUARTER;
         car_ph_ff <= PHASE_QUARTER;
         last_mod_ff <= '0;
         amp_env_ff <= ENV_ONE;
         mod_env_ff <= ENV_ONE;
         hp_in_ff <= '0;
         hp_out_ff <= '0;
         stage_ff <= '0;
         gap_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_CARRIER_STEP: carrier_step_ff <= csr_data;
               CSR_MOD_STEP:     mod_step_ff <= csr_data;
               CSR_MOD_DEPTH:    mod_depth_ff <= csr_data[19:0];
               CSR_MOD_DECAY:    mod_decay_ff <= csr_data[23:0];
               CSR_AMP_DECAY_A:  amp_decay_a_ff <= csr_data[23:0];
               CSR_AMP_DECAY_B:  amp_decay_b_ff <= csr_data[23:0];
               CSR_GAP_SAMPLES:  gap_samples_ff <= csr_data[15:0];
               CSR_BURST_COUNT:  burst_count_ff <= csr_data[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               // retrigger restarts the voice before this sample
               if (req_take && req_retrigger) begin
                  mod_ph_ff <= PHASE_QUARTER;
                  car_ph_ff <= PHASE_QUARTER;
                  last_mod_ff <= '0;
                  amp_env_ff <= ENV_ONE;
                  mod_env_ff <= ENV_ONE;
                  hp_in_ff <= '0;
                  hp_out_ff <= '0;
                  stage_ff <= '0;
                  gap_ff <= '0;
                  sounding_ff <= 1'b1;
               end
            end
            S_MPH:  mod_ph_ff <= mod_ph_ff + mod_step_ff + prod[31:0];
            S_MSIN: depth_ff <= prod[43:24];
            S_DEP:  last_mod_ff <= sine;
            S_OFF:  car_ph_ff <= car_ph_ff + carrier_step_ff + prod[31:0];
            S_AMP:  tone_neg_ff <= sine[15];
            S_SCL:  x_ff <= x_val;
            S_HP:   hp_neg_ff <= hp_s[18];
            S_HPW: begin
               hp_in_ff <= x_ff;
               hp_out_ff <= hp_sat;
               sample_ff <= sample_sat;
            end
            S_MENV: mod_env_ff <= prod[47:24];
            S_AENV: begin
               // stage boundary restarts both envelopes
               if (gap_next >= gap_samples_ff) begin
                  gap_ff <= '0;
                  stage_ff <= stage_next;
                  mod_env_ff <= ENV_ONE;
                  amp_env_ff <= ENV_ONE;
                  if ({1'b0, stage_next} >= 9'(burst_count_ff) + 9'd1)
                     sounding_ff <= 1'b0;
               end else begin
                  gap_ff <= gap_next;
                  amp_env_ff <= prod[47:24];
               end
            end
            // silent voice, no retrigger
            S_DONE: sample_ff <= '0;
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready with pending result");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_AENV) || (state_ff == S_DONE)) |=> rsp_valid)
      else $error("result not raised");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (rsp_sample_out == 16'sd0 && !rsp_voice_active))
      else $error("idle voice not silent");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)
                                     && $stable(rsp_voice_active)))
      else $error("result changed while waiting");
endmodule
`default_nettype wire
